FILE: rtl/line_substring_matcher_unit_macros.svh
// Assertion macros used by the line substring matcher top-level RTL.
`ifndef LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is asserted
`define LSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked property, also evaluated during reset
`define LSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/lsm_pkg.sv
// Package: constants, types and helpers of the line substring matcher.
`default_nettype none
package lsm_pkg;

    // Pattern storage
    localparam int MAX_PATTERN  = 16;
    localparam int STORED_BYTES = 16;
    localparam int HIT_W        = (MAX_PATTERN < STORED_BYTES) ? MAX_PATTERN : STORED_BYTES;
    localparam int LEN_W        = 5;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(HIT_W);

    // Character codes
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CASE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd4;

    // Configuration as seen by the compare logic
    typedef struct packed {
        logic [127:0]      pattern;
        logic [LEN_W-1:0]  pattern_length;
        logic              fold_case;
    } t_match_cfg;

    // Per-line match state
    typedef struct packed {
        logic [HIT_W-1:0] prefix_hits;
        logic             line_hit;
        logic             nul_seen;
    } t_line_state;

    // Fold A-Z to lower case when enabled
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lsm_in_if.sv
// Interface: text byte request channel.
`default_nettype none
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsm_out_if.sv
// Interface: per-line result request channel.
`default_nettype none
interface lsm_out_if;
    logic        valid;
    logic        ready;
    logic        line_selected;
    logic [31:0] line_number;
    logic        any_selected;

    modport source (output valid, output line_selected, output line_number,
                    output any_selected, input ready);
    modport sink   (input valid, input line_selected, input line_number,
                    input any_selected, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsm_match_core.sv
// Shift-and update of the per-line match state for one text byte.
`default_nettype none
module lsm_match_core (
    input  var lsm_pkg::t_match_cfg  i_cfg,
    input  var logic [7:0]           i_text_byte,
    input  var lsm_pkg::t_line_state i_state,
    output lsm_pkg::t_line_state     o_state,
    output logic                     o_len_zero
);
    import lsm_pkg::*;

    logic [LEN_W-1:0] eff_len;
    logic [7:0]       folded_byte;
    logic [HIT_W-1:0] eq_vec;
    logic [HIT_W-1:0] last_sel;
    logic [HIT_W-1:0] n_hits;

    // Clamp the length to the stored pattern size
    assign eff_len     = (i_cfg.pattern_length > MAX_LEN) ? MAX_LEN : i_cfg.pattern_length;
    assign folded_byte = fold_char(i_text_byte, i_cfg.fold_case);
    assign o_len_zero  = (eff_len == '0);

    // Per-position compare, only positions inside the pattern
    always_comb begin
        for (int j = 0; j < HIT_W; j++) begin
            eq_vec[j]   = (LEN_W'(j) < eff_len) &&
                          (fold_char(i_cfg.pattern[8*j +: 8], i_cfg.fold_case) == folded_byte);
            last_sel[j] = (LEN_W'(j + 1) == eff_len);
        end
    end

    assign n_hits = {i_state.prefix_hits[HIT_W-2:0], 1'b1} & eq_vec;

    // Next state; a NUL freezes the rest of the line
    always_comb begin
        o_state = i_state;
        if (!i_state.nul_seen) begin
            if (i_text_byte == CHAR_NUL) begin
                o_state.nul_seen    = 1'b1;
                o_state.prefix_hits = '0;
            end else begin
                o_state.prefix_hits = n_hits;
                if (|(n_hits & last_sel)) begin
                    o_state.line_hit = 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/line_substring_matcher_unit.sv
// Line substring matcher: per-line pattern search over a byte stream.
//
// Usage:
//   i_text carries one text byte per request plus a stream_end flag.
//   o_result carries one request per finished line: the selected flag
//   (hit XOR invert), the 1-based saturating line number and a sticky
//   any-selected flag. A line finishes at a newline byte or at a byte
//   marked stream_end; a newline that also ends the stream gives one result.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; indexes past the register list are ignored.
// Timing:
//   One byte per cycle sustained while the receiver takes line results. A
//   byte is registered on entry, then the shift-and compare and the line
//   bookkeeping run combinationally into the result register. The rate is
//   set by the prefix-hit update loop.
// Reset and stalls:
//   Synchronous active-low reset clears the pattern registers, line state,
//   line counter and the sticky flag. When the receiver stalls, the input
//   register keeps taking bytes that finish no line; a byte that finishes
//   a line waits there until the result register frees up.
`default_nettype none
`include "line_substring_matcher_unit_macros.svh"
module line_substring_matcher_unit (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           i_cfg_we,
    input  var logic [lsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  var logic [lsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lsm_in_if.sink                             i_text,
    lsm_out_if.source                          o_result
);
    import lsm_pkg::*;

    // Configuration registers
    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [LEN_W-1:0] r_pattern_len;
    logic             r_fold_case;
    logic             r_invert;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // Line state
    t_line_state      r_state;
    t_line_state      n_state;
    logic [31:0]      r_line_count;
    logic [31:0]      n_line_count;
    logic             r_any_hit;
    logic             n_any_hit;

    // Result register
    logic             r_out_valid;
    logic             r_out_sel;
    logic [31:0]      r_out_number;
    logic             r_out_any;

    t_match_cfg       match_cfg;
    t_line_state      core_state;
    logic             len_zero;
    logic             stage_close;
    logic             stage_adv;
    logic             line_sel;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_pattern_len  <= '0;
            r_fold_case    <= 1'b0;
            r_invert       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pattern_low  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_data;
                CFG_PATTERN_LEN:  r_pattern_len  <= i_cfg_data[LEN_W-1:0];
                CFG_FOLD_CASE:    r_fold_case    <= i_cfg_data[0];
                CFG_INVERT:       r_invert       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign match_cfg = '{pattern: {r_pattern_high, r_pattern_low},
                         pattern_length: r_pattern_len,
                         fold_case: r_fold_case};

    // Stage control: a closing byte needs a free result register
    assign stage_close = (r_in_byte == CHAR_NEWLINE) || r_in_last;
    assign stage_adv   = r_in_valid && (!stage_close || !r_out_valid || o_result.ready);
    assign i_text.ready = !r_in_valid || stage_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.stream_end;
        end
    end

    lsm_match_core u_match_core (
        .i_cfg       (match_cfg),
        .i_text_byte (r_in_byte),
        .i_state     (r_state),
        .o_state     (core_state),
        .o_len_zero  (len_zero)
    );

    // Line bookkeeping
    assign line_sel = (core_state.line_hit || len_zero) != r_invert;

    always_comb begin
        n_state      = core_state;
        n_line_count = r_line_count;
        n_any_hit    = r_any_hit;
        if (stage_close) begin
            n_state = '0;
            if (r_line_count != '1) begin
                n_line_count = r_line_count + 32'd1;
            end
            if (line_sel) begin
                n_any_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_line_count <= '0;
            r_any_hit    <= 1'b0;
        end else if (stage_adv) begin
            r_state      <= n_state;
            r_line_count <= (stage_close && r_in_last) ? 32'd0 : n_line_count;
            r_any_hit    <= n_any_hit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_adv && stage_close) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv && stage_close) begin
            r_out_sel    <= line_sel;
            r_out_number <= n_line_count;
            r_out_any    <= n_any_hit;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.line_selected = r_out_sel;
    assign o_result.line_number   = r_out_number;
    assign o_result.any_selected  = r_out_any;

    // Checks
    `LSM_ASSERT(a_line_number_nonzero, i_clk, i_rst_n,
        r_out_valid |-> (r_out_number != 32'd0), "result line number is zero")
    `LSM_ASSERT(a_any_follows_sel, i_clk, i_rst_n,
        (r_out_valid && r_out_sel) |-> r_out_any, "selected line without any-selected")
    `LSM_ASSERT(a_count_restart, i_clk, i_rst_n,
        (stage_adv && r_in_last) |=> (r_line_count == 32'd0), "line count kept past stream end")
    `LSM_ASSERT_ALWAYS(a_nul_clears_hits, i_clk,
        r_state.nul_seen |-> (r_state.prefix_hits == '0), "prefix hits live after NUL")
    `LSM_ASSERT(a_stall_only_full, i_clk, i_rst_n,
        !i_text.ready |-> (r_in_valid && stage_close && r_out_valid),
        "input stalled without a blocked closing byte")

endmodule
`default_nettype wire

FILE: test/line_substring_matcher_unit_tb.sv
// Testbench for the line substring matcher: directed and random text checked against a predictor.
module line_substring_matcher_unit_tb;
    import lsm_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_PRINTED   = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam logic [7:0] CHAR_LOWER_A = CHAR_UPPER_A + CASE_OFFSET;
    localparam logic [7:0] CHAR_LOWER_Z = CHAR_UPPER_Z + CASE_OFFSET;

    // One finished line as the block reports it
    typedef struct packed {
        logic        selected;
        logic [31:0] number;
        logic        any;
    } t_line_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lsm_in_if  text_if ();
    lsm_out_if result_if ();

    line_substring_matcher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_text      (text_if),
        .o_result    (result_if)
    );

    // Predictor copy of the registers and the line state
    logic [127:0]     pattern_bytes = '0;
    logic [LEN_W-1:0] pattern_len   = '0;
    logic             fold_en       = 1'b0;
    logic             invert_en     = 1'b0;
    logic [HIT_W-1:0] prefix_bits   = '0;
    logic             line_hit_flag = 1'b0;
    logic             nul_flag      = 1'b0;
    logic [31:0]      line_counter  = '0;
    logic             any_flag      = 1'b0;

    t_line_result pending_lines[$];

    int   errors        = 0;
    int   items_sent    = 0;
    int   lines_checked = 0;
    int   setups_loaded = 0;
    int   cycle_count   = 0;
    bit   src_idling    = 1'b1;
    bit   sink_idling   = 1'b1;
    logic hold_off      = 1'b0;
    event hold_off_go;

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d lines still pending",
                     cycle_count, pending_lines.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        return (fold_en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Pattern bytes actually compared, after clamping the length
    function automatic int live_length();
        return (pattern_len > HIT_W) ? HIT_W : int'(pattern_len);
    endfunction

    function automatic logic [127:0] pack_pattern(input string s);
        logic [127:0] p;
        p = '0;
        for (int i = 0; i < s.len(); i++) p[8*i +: 8] = s[i];
        return p;
    endfunction

    // Shift-and update for one accepted byte; queues a result when the line closes
    task automatic scan_text_byte(input logic [7:0] c, input logic last);
        int               n;
        logic [HIT_W-1:0] eq;
        logic             hit;
        t_line_result     r;
        n = live_length();
        if (!nul_flag) begin
            if (c == CHAR_NUL) begin
                nul_flag    = 1'b1;
                prefix_bits = '0;
            end else begin
                eq = '0;
                for (int j = 0; j < n; j++) begin
                    eq[j] = (fold_letter(pattern_bytes[8*j +: 8]) == fold_letter(c));
                end
                prefix_bits = {prefix_bits[HIT_W-2:0], 1'b1} & eq;
                if (n > 0 && prefix_bits[n-1]) line_hit_flag = 1'b1;
            end
        end
        if (c == CHAR_NEWLINE || last) begin
            hit        = line_hit_flag || (n == 0);
            r.selected = hit ^ invert_en;
            if (line_counter != '1) line_counter++;
            if (r.selected) any_flag = 1'b1;
            r.number = line_counter;
            r.any    = any_flag;
            pending_lines.push_back(r);
            prefix_bits   = '0;
            line_hit_flag = 1'b0;
            nul_flag      = 1'b0;
            if (last) line_counter = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("MISMATCH %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
        end
    endtask

    task automatic check_line();
        t_line_result want;
        if (pending_lines.size() == 0) begin
            report_mismatch("unexpected line result, number", 32'd0, result_if.line_number);
            return;
        end
        want = pending_lines.pop_front();
        lines_checked++;
        if (result_if.line_selected !== want.selected)
            report_mismatch("line_selected", 32'(want.selected),
                            32'(result_if.line_selected));
        if (result_if.line_number !== want.number)
            report_mismatch("line_number", want.number, result_if.line_number);
        if (result_if.any_selected !== want.any)
            report_mismatch("any_selected", 32'(want.any), 32'(result_if.any_selected));
    endtask

    // Monitor: check finished lines, feed accepted bytes to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) check_line();
            if (text_if.valid === 1'b1 && text_if.ready === 1'b1)
                scan_text_byte(text_if.text_byte, text_if.stream_end);
        end
    end

    // Result receiver: random stall bursts plus the long hold-off
    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off || i_rst_n !== 1'b1) begin
                result_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_off_go);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Offer one byte request and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (src_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_if.valid      <= 1'b1;
        text_if.text_byte  <= b;
        text_if.stream_end <= last;
        do @(posedge i_clk); while (text_if.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_string(input string s, input bit close_stream);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], close_stream && (i == s.len() - 1));
    endtask

    // Let every pending line come out, then give the pipeline time to empty
    task automatic wait_idle();
        text_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:  pattern_bytes[63:0]   = data;
            CFG_PATTERN_HIGH: pattern_bytes[127:64] = data;
            CFG_PATTERN_LEN:  pattern_len           = data[LEN_W-1:0];
            CFG_FOLD_CASE:    fold_en               = data[0];
            CFG_INVERT:       invert_en             = data[0];
            default: ;
        endcase
    endtask

    // Full register setup while idle; unused upper data bits sometimes carry noise
    task automatic load_setup(input logic [127:0] pat, input logic [LEN_W-1:0] len,
                              input logic fc, input logic inv);
        logic [63:0] noise;
        wait_idle();
        noise = ($urandom_range(0, 1) == 1) ? rand64() : '0;
        write_cfg(CFG_UNUSED_IDX, rand64());
        write_cfg(CFG_PATTERN_LOW, pat[63:0]);
        write_cfg(CFG_PATTERN_HIGH, pat[127:64]);
        write_cfg(CFG_PATTERN_LEN, {noise[63:LEN_W], len});
        write_cfg(CFG_FOLD_CASE, {noise[63:1], fc});
        write_cfg(CFG_INVERT, {noise[63:1], inv});
        i_cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    task automatic load_random_setup();
        logic [127:0]     pat;
        logic [LEN_W-1:0] len;
        logic [7:0]       b;
        case ($urandom_range(0, 7))
            0:       len = '0;
            1:       len = LEN_W'(1);
            2:       len = MAX_LEN;
            3:       len = LEN_W'($urandom_range(17, 31));
            default: len = LEN_W'($urandom_range(2, 15));
        endcase
        if ($urandom_range(0, 5) == 0) begin
            pat = {rand64(), rand64()};
        end else begin
            // Small alphabet so partial matches are common
            for (int i = 0; i < 16; i++) begin
                case ($urandom_range(0, 39))
                    0:       b = CHAR_NUL;
                    1, 2:    b = CHAR_NEWLINE;
                    3, 4, 5: b = 8'($urandom_range(1, 255));
                    default: b = ($urandom_range(0, 1) == 1) ?
                                 flip_case(CHAR_LOWER_A + 8'($urandom_range(0, 3))) :
                                 CHAR_LOWER_A + 8'($urandom_range(0, 3));
                endcase
                pat[8*i +: 8] = b;
            end
        end
        load_setup(pat, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] filler_byte();
        int         n;
        logic [7:0] b;
        n = live_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                b = (n > 0) ? pattern_bytes[8*$urandom_range(0, n - 1) +: 8] :
                              CHAR_LOWER_A + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) b = flip_case(b);
            end
            5, 6, 7: begin
                b = CHAR_LOWER_A + 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) b = flip_case(b);
            end
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // One line: filler with the pattern or a prefix of it, now and then a NUL or pure noise
    task automatic send_random_line();
        logic [7:0] line_q[$];
        logic [7:0] b;
        int         n, k, pos, ending;
        bit         closing;
        n = live_length();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 12)) line_q.push_back(filler_byte());
            pos = $urandom_range(0, line_q.size());
            case ($urandom_range(0, 3))
                0, 1:    k = n;
                2:       k = $urandom_range(0, n);
                default: k = 0;
            endcase
            for (int j = 0; j < k; j++) begin
                b = pattern_bytes[8*j +: 8];
                if ((fold_en && $urandom_range(0, 1) == 1) || $urandom_range(0, 7) == 0)
                    b = flip_case(b);
                line_q.insert(pos + j, b);
            end
            if ($urandom_range(0, 11) == 0)
                line_q.insert($urandom_range(0, line_q.size()), CHAR_NUL);
        end
        // Close with a newline, a newline that ends the stream, or a plain final byte
        ending  = $urandom_range(0, 19);
        closing = (ending <= 2);
        if (ending > 0 && ending <= 2) begin
            if (line_q.size() == 0) line_q.push_back(filler_byte());
        end else begin
            line_q.push_back(CHAR_NEWLINE);
        end
        foreach (line_q[i]) send_byte(line_q[i], closing && (i == line_q.size() - 1));
    endtask

    task automatic send_random_lines(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) send_random_line();
    endtask

    // Corner cases one by one
    task automatic test_directed_cases();
        // folding applies to both pattern and text
        load_setup(pack_pattern("Ab"), LEN_W'(2), 1'b1, 1'b0);
        send_string("aB\n", 1'b0);
        // a NUL hides the rest of its line
        send_byte(CHAR_NUL, 1'b0);
        send_string("ab\n", 1'b0);
        // no folding: case differs, miss
        load_setup(pack_pattern("Ab"), LEN_W'(2), 1'b0, 1'b0);
        send_string("aB\n", 1'b0);
        // newline inside the pattern matches at the line end
        load_setup(pack_pattern("x\n"), LEN_W'(2), 1'b0, 1'b0);
        send_string("x\n", 1'b0);
        // a zero pattern byte never matches
        load_setup('0, LEN_W'(1), 1'b0, 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        // length past the maximum is clamped, inverted
        load_setup(pack_pattern("q"), 5'd31, 1'b1, 1'b1);
        send_string("Q\n", 1'b0);
        // empty pattern hits every line; newline with stream end, then top byte ending the stream
        load_setup('0, '0, 1'b0, 1'b1);
        send_byte(CHAR_NEWLINE, 1'b1);
        send_byte(8'hFF, 1'b1);
        load_setup({16{8'hFF}}, MAX_LEN, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_random_lines();
        for (int phase = 0; phase < 10; phase++) begin
            load_random_setup();
            send_random_lines(90);
        end
    endtask

    // Receiver holds off while requests keep coming, so the input backs up
    task automatic test_receiver_hold();
        load_random_setup();
        src_idling = 1'b0;
        -> hold_off_go;
        send_random_lines(100);
        src_idling = 1'b1;
    endtask

    // Back-to-back requests on both sides
    task automatic test_full_rate();
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        for (int phase = 0; phase < 3; phase++) begin
            load_random_setup();
            send_random_lines(50);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        text_if.valid      = 1'b0;
        text_if.text_byte  = '0;
        text_if.stream_end = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_lines();
        test_receiver_hold();
        test_full_rate();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d text bytes into %0d checked lines across %0d register setups,",
                 items_sent, lines_checked, setups_loaded);
        $display("with corner cases, a long receiver hold-off and a full-rate stretch.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_in_if.sv
rtl/lsm_out_if.sv
rtl/lsm_match_core.sv
rtl/line_substring_matcher_unit.sv
test/line_substring_matcher_unit_tb.sv
